// ===== hdl/ipv6ehw_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the ipv6 extension header walker
// no dependencies; imported by the core and its checker

package ipv6ehw_pkg;

    localparam int POSITION_BITS_DEF = 16;

    // result status codes
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_BAD_MSG   = 2'd2;

    // protocol numbers of headers that can be walked
    localparam logic [7:0] PROTO_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] PROTO_ROUTING    = 8'd43;
    localparam logic [7:0] PROTO_FRAGMENT   = 8'd44;
    localparam logic [7:0] PROTO_AUTH       = 8'd51;
    localparam logic [7:0] PROTO_DEST_OPTS  = 8'd60;

    // register indexes on the apb port
    localparam logic REG_FIND_LAST_HEADER = 1'b0;
    localparam logic REG_TARGET_PROTOCOL  = 1'b1;

    localparam logic [7:0]  TARGET_PROTOCOL_RST = 8'd6;
    localparam logic [15:0] FRAG_OFFSET_MASK    = 16'hFFF8;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  protocol;
        logic [15:0] header_offset;
        logic [15:0] fragment_offset;
    } result_t;

    function automatic logic walkable(input logic [7:0] nh);
        walkable = (nh == PROTO_HOP_BY_HOP) || (nh == PROTO_ROUTING) ||
                   (nh == PROTO_FRAGMENT) || (nh == PROTO_AUTH) ||
                   (nh == PROTO_DEST_OPTS);
    endfunction

endpackage

// ===== hdl/ipv6_extension_header_walker_core.sv =====
`timescale 1ns / 1ps
// ipv6 extension header chain walker, single-pass byte datapath with output skid
// depends on ipv6ehw_pkg

// Takes an IPv6 packet as a stream of byte beats on the item channel (data_byte,
// first_byte, last_byte) and walks its extension header chain on the fly: the
// next-header field at byte 6 names the first header at offset 40, after which
// hop-by-hop, routing, fragment, AH and destination options headers are skipped
// using their length bytes. Each packet yields at most one result beat, issued on
// the byte that settles the walk: found (protocol and its byte offset), not found,
// or bad message when the packet ends before the walk is settled, including
// packets shorter than 40 bytes. With find_last_header set, the first header that
// cannot be walked is reported, and a non-first fragment ends the walk with the
// fragment offset when found. Throughput is one byte per clock while the skid is
// empty: each beat is judged by a compare and one length add between the walk
// state registers and the result register, and a two-entry output (result
// register plus skid) lets the core keep taking bytes while a result waits.
// Registers over APB: find_last_header at 0x0 (reset 1), target_protocol at 0x4
// (reset 6); write only while the core is idle.

module ipv6_extension_header_walker_core #(
    parameter int POSITION_BITS = ipv6ehw_pkg::POSITION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte beats in
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    // result beats out
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic [7:0]  protocol,
    output logic [15:0] header_offset,
    output logic [15:0] fragment_offset
);

    import ipv6ehw_pkg::*;

    localparam int P     = POSITION_BITS;
    // header length is at most 256*8, which needs 12 bits
    localparam int LEN_W = 12;
    localparam int SUM_W = ((P > LEN_W) ? P : LEN_W) + 1;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    typedef struct packed {
        logic [P-1:0] pos;
        logic [7:0]   cur_nh;
        logic [P-1:0] hstart;
        logic [7:0]   pend_nh;
        logic [7:0]   pend_len;
        logic [7:0]   frag_hi;
        logic         decided;
    } walk_state_t;

    localparam walk_state_t WALK_RST = '{
        pos:      '0,
        cur_nh:   '0,
        hstart:   P'(40),
        pend_nh:  '0,
        pend_len: '0,
        frag_hi:  '0,
        decided:  1'b0
    };

    // configuration registers
    logic       find_last_reg;
    logic [7:0] target_reg;

    walk_state_t walk_reg, walk_next;

    // output register and skid entry
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic    item_fire;
    logic    out_take;
    logic    res_hit;
    result_t res;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_last_reg <= 1'b1;
            target_reg    <= TARGET_PROTOCOL_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_FIND_LAST_HEADER: find_last_reg <= pwdata[0];
                REG_TARGET_PROTOCOL:  target_reg    <= pwdata[7:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIND_LAST_HEADER: prdata = {31'd0, find_last_reg};
            REG_TARGET_PROTOCOL:  prdata = {24'd0, target_reg};
            default:              prdata = '0;
        endcase
    end

    // ---------------- walk logic ----------------
    // judge the header named by nh that starts at hs
    function automatic logic [$bits(result_t):0] judge(
        input logic [7:0]   nh,
        input logic [P-1:0] hs,
        input logic         find_last,
        input logic [7:0]   target
    );
        logic [P+15:0] hs_ext;
        result_t       r;
        logic          hit;
        hs_ext = {16'd0, hs};
        r      = '0;
        hit    = 1'b0;
        if (!find_last && nh == target)
        begin
            hit             = 1'b1;
            r.status        = STATUS_FOUND;
            r.protocol      = nh;
            r.header_offset = hs_ext[15:0];
        end
        else if (!walkable(nh))
        begin
            hit = 1'b1;
            if (find_last)
            begin
                r.status        = STATUS_FOUND;
                r.protocol      = nh;
                r.header_offset = hs_ext[15:0];
            end
            else
            begin
                r.status = STATUS_NOT_FOUND;
            end
        end
        judge = {hit, r};
    endfunction

    // next header start, clamped at the top of the position range
    function automatic logic [P-1:0] advance_start(
        input logic [P-1:0]     hs,
        input logic [LEN_W-1:0] len
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(hs) + SUM_W'(len);
        if (sum > SUM_W'(POS_MAX))
            advance_start = POS_MAX;
        else
            advance_start = sum[P-1:0];
    endfunction

    walk_state_t          cur;
    logic [P-1:0]         p;
    logic [P-1:0]         rel;
    logic [LEN_W-1:0]     hdr_len;
    logic [15:0]          frag_field;
    logic [P+15:0]        hs_ext;
    logic [$bits(result_t):0] verdict;

    always_comb
    begin
        cur      = first_byte ? WALK_RST : walk_reg;
        walk_next = cur;
        p        = cur.pos;
        rel      = p - cur.hstart;
        res_hit  = 1'b0;
        res      = '0;
        verdict  = '0;
        hs_ext   = {16'd0, cur.hstart};
        frag_field = {cur.frag_hi, data_byte} & FRAG_OFFSET_MASK;
        if (cur.cur_nh == PROTO_AUTH)
            hdr_len = (LEN_W'(data_byte) + LEN_W'(2)) << 2;
        else
            hdr_len = (LEN_W'(data_byte) + LEN_W'(1)) << 3;

        if (!cur.decided)
        begin
            if (p == P'(6))
                walk_next.cur_nh = data_byte;
            if (p == P'(39))
            begin
                verdict = judge(cur.cur_nh, cur.hstart, find_last_reg, target_reg);
            end
            else if (p >= P'(40) && p != POS_MAX && p >= cur.hstart)
            begin
                if (rel == P'(0))
                begin
                    walk_next.pend_nh = data_byte;
                end
                else if (rel == P'(1))
                begin
                    walk_next.pend_len = data_byte;
                    if (cur.cur_nh != PROTO_FRAGMENT)
                    begin
                        walk_next.hstart = advance_start(cur.hstart, hdr_len);
                        walk_next.cur_nh = cur.pend_nh;
                        verdict = judge(walk_next.cur_nh, walk_next.hstart,
                                        find_last_reg, target_reg);
                    end
                end
                else if (rel == P'(2))
                begin
                    walk_next.frag_hi = data_byte;
                end
                else if (rel == P'(3))
                begin
                    if (frag_field != 16'd0)
                    begin
                        // non-first fragment ends the walk
                        verdict[$bits(result_t)] = 1'b1;
                        if (find_last_reg && !walkable(cur.pend_nh))
                        begin
                            verdict[$bits(result_t)-1:0] = result_t'{
                                STATUS_FOUND, cur.pend_nh, hs_ext[15:0], frag_field};
                        end
                        else
                        begin
                            verdict[$bits(result_t)-1:0] = result_t'{
                                STATUS_NOT_FOUND, 8'd0, 16'd0, 16'd0};
                        end
                    end
                    else
                    begin
                        walk_next.hstart = advance_start(cur.hstart, LEN_W'(8));
                        walk_next.cur_nh = cur.pend_nh;
                        verdict = judge(walk_next.cur_nh, walk_next.hstart,
                                        find_last_reg, target_reg);
                    end
                end
            end
        end

        res_hit = verdict[$bits(result_t)];
        res     = verdict[$bits(result_t)-1:0];
        if (res_hit)
            walk_next.decided = 1'b1;

        // packet ended before the walk settled
        if (!walk_next.decided && last_byte)
        begin
            res_hit = 1'b1;
            res     = result_t'{STATUS_BAD_MSG, 8'd0, 16'd0, 16'd0};
            walk_next.decided = 1'b1;
        end

        if (last_byte)
            walk_next = WALK_RST;
        else if (p != POS_MAX)
            walk_next.pos = p + P'(1);
    end

    assign item_ready = !skid_valid_reg;
    assign item_fire  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            walk_reg <= WALK_RST;
        else if (item_fire)
            walk_reg <= walk_next;
    end

    // ---------------- result register and skid ----------------
    assign out_take = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= item_fire && res_hit;
            end
            else
            begin
                out_valid_reg <= item_fire && res_hit;
            end
        end
        else if (item_fire && res_hit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (item_fire && res_hit)
        begin
            skid_reg <= res;
        end
    end

    assign result_valid    = out_valid_reg;
    assign status          = out_reg.status;
    assign protocol        = out_reg.protocol;
    assign header_offset   = out_reg.header_offset;
    assign fragment_offset = out_reg.fragment_offset;

endmodule

// ===== hdl/ipv6ehw_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the ipv6 extension header walker, with its bind
// depends on ipv6ehw_pkg and ipv6_extension_header_walker_core

module ipv6ehw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  status,
    input logic [7:0]  protocol,
    input logic [15:0] header_offset,
    input logic [15:0] fragment_offset
);

    import ipv6ehw_pkg::*;

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status) &&
        $stable(protocol) && $stable(header_offset) && $stable(fragment_offset))
        else $error("result beat changed while stalled");

    // status is one of the three defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == STATUS_FOUND || status == STATUS_NOT_FOUND ||
                          status == STATUS_BAD_MSG))
        else $error("undefined status code");

    // only a found result carries a protocol, offset or fragment offset
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != STATUS_FOUND |->
        protocol == 8'd0 && header_offset == 16'd0 && fragment_offset == 16'd0)
        else $error("miss result carries header fields");

    // fragment offset is in units of eight bytes
    a_frag_align: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> fragment_offset[2:0] == 3'd0)
        else $error("fragment offset not 8-byte aligned");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind ipv6_extension_header_walker_core ipv6ehw_checker u_ipv6ehw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pready          (pready),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .status          (status),
    .protocol        (protocol),
    .header_offset   (header_offset),
    .fragment_offset (fragment_offset)
);

// ===== sim/ipv6ehw_walk_checker.sv =====
`timescale 1ns / 1ps
// result checker for the ipv6 extension header walker: follows apb writes and byte
// beats, predicts each result beat and compares the result channel against it
// depends on ipv6ehw_pkg

module ipv6ehw_walk_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [1:0]  status,
    input  logic [7:0]  protocol,
    input  logic [15:0] header_offset,
    input  logic [15:0] fragment_offset,
    output int          errors,
    output int          pending,
    output int          beats_in,
    output int          found_cnt,
    output int          missing_cnt,
    output int          bad_cnt
);

    import ipv6ehw_pkg::*;

    localparam int POS_LIMIT = (1 << POSITION_BITS_DEF) - 1;
    localparam int SHOW_MAX  = 40;

    // register copies
    bit         seek_last;
    logic [7:0] seek_proto;

    // walk state of the current packet
    int         walk_pos;
    int         walk_hdr;
    logic [7:0] walk_nh;
    logic [7:0] next_nh;
    logic [7:0] frag_msb;
    bit         settled;

    result_t    pending_outcomes[$];
    int         err_total;
    int         beat_total;
    int         n_found;
    int         n_missing;
    int         n_bad;
    int         shown;

    function automatic bit chainable(input logic [7:0] nh);
        return nh == PROTO_HOP_BY_HOP || nh == PROTO_ROUTING || nh == PROTO_FRAGMENT ||
               nh == PROTO_AUTH || nh == PROTO_DEST_OPTS;
    endfunction

    task automatic restart_walk();
        walk_pos = 0;
        walk_hdr = 40;
        walk_nh  = '0;
        next_nh  = '0;
        frag_msb = '0;
        settled  = 1'b0;
    endtask

    task automatic settle(output bit hit, output result_t r, input logic [1:0] st,
                          input logic [7:0] pr, input logic [15:0] off,
                          input logic [15:0] fo);
        r.status          = st;
        r.protocol        = pr;
        r.header_offset   = off;
        r.fragment_offset = fo;
        hit     = 1'b1;
        settled = 1'b1;
    endtask

    // decide on the header named by walk_nh at walk_hdr
    task automatic judge(output bit hit, output result_t r);
        hit = 1'b0;
        r   = '0;
        if (!seek_last && walk_nh == seek_proto)
            settle(hit, r, STATUS_FOUND, walk_nh, walk_hdr[15:0], '0);
        else if (!chainable(walk_nh))
        begin
            if (seek_last)
                settle(hit, r, STATUS_FOUND, walk_nh, walk_hdr[15:0], '0);
            else
                settle(hit, r, STATUS_NOT_FOUND, '0, '0, '0);
        end
    endtask

    task automatic step_over(input int len);
        walk_hdr = (walk_hdr + len > POS_LIMIT) ? POS_LIMIT : walk_hdr + len;
        walk_nh  = next_nh;
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic f, input logic l,
                             output bit hit, output result_t r);
        int         p;
        int         rel;
        int         len;
        logic [15:0] fo;
        hit = 1'b0;
        r   = '0;
        if (f)
            restart_walk();
        p = walk_pos;
        if (!settled)
        begin
            if (p == 6)
                walk_nh = b;
            if (p == 39)
                judge(hit, r);
            else if (p >= 40 && p < POS_LIMIT && p >= walk_hdr)
            begin
                rel = p - walk_hdr;
                case (rel)
                    0: next_nh = b;
                    1:
                    begin
                        if (walk_nh != PROTO_FRAGMENT)
                        begin
                            len = (walk_nh == PROTO_AUTH) ? (int'(b) + 2) * 4
                                                          : (int'(b) + 1) * 8;
                            step_over(len);
                            judge(hit, r);
                        end
                    end
                    2: frag_msb = b;
                    3:
                    begin
                        fo = {frag_msb, b} & FRAG_OFFSET_MASK;
                        if (fo != '0)
                        begin
                            if (seek_last && !chainable(next_nh))
                                settle(hit, r, STATUS_FOUND, next_nh, walk_hdr[15:0], fo);
                            else
                                settle(hit, r, STATUS_NOT_FOUND, '0, '0, '0);
                        end
                        else
                        begin
                            step_over(8);
                            judge(hit, r);
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (!settled && l)
            settle(hit, r, STATUS_BAD_MSG, '0, '0, '0);
        if (l)
            restart_walk();
        else if (p < POS_LIMIT)
            walk_pos = p + 1;
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            err_total++;
            if (shown < SHOW_MAX)
            begin
                shown++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bit      hit;
        result_t want;
        if (!rst_n)
        begin
            seek_last  = 1'b1;
            seek_proto = TARGET_PROTOCOL_RST;
            restart_walk();
            pending_outcomes.delete();
            err_total  = 0;
            beat_total = 0;
            n_found    = 0;
            n_missing  = 0;
            n_bad      = 0;
            shown      = 0;
        end
        else
        begin
            // result side first: a result never belongs to a beat taken at this edge
            if (result_valid && result_ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    err_total++;
                    if (shown < SHOW_MAX)
                    begin
                        shown++;
                        $display("%0t: result beat, expected none, got %0d/%0d/%0d/%0d",
                                 $time, status, protocol, header_offset, fragment_offset);
                    end
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("protocol", 16'(want.protocol), 16'(protocol));
                    check_field("header_offset", want.header_offset, header_offset);
                    check_field("fragment_offset", want.fragment_offset, fragment_offset);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_FIND_LAST_HEADER)
                    seek_last = pwdata[0];
                else
                    seek_proto = pwdata[7:0];
            end
            if (item_valid && item_ready)
            begin
                beat_total++;
                walk_byte(data_byte, first_byte, last_byte, hit, want);
                if (hit)
                begin
                    pending_outcomes.push_back(want);
                    if (want.status == STATUS_FOUND)
                        n_found++;
                    else if (want.status == STATUS_NOT_FOUND)
                        n_missing++;
                    else
                        n_bad++;
                end
            end
        end
        errors      <= err_total;
        pending     <= pending_outcomes.size();
        beats_in    <= beat_total;
        found_cnt   <= n_found;
        missing_cnt <= n_missing;
        bad_cnt     <= n_bad;
    end

endmodule

// ===== sim/ipv6_extension_header_walker_core_test.sv =====
`timescale 1ns / 1ps
// top of the ipv6 extension header walker test: clock, reset, apb setup, packet
// stimulus and verdict; depends on ipv6ehw_pkg, the core and ipv6ehw_walk_checker

module ipv6_extension_header_walker_core_test;

    import ipv6ehw_pkg::*;

    // upper layer protocol numbers used to end a chain
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] PROTO_ICMP6   = 8'd58;
    localparam logic [7:0] PROTO_NO_NEXT = 8'd59;

    localparam logic [2:0] ADDR_FIND_LAST = {REG_FIND_LAST_HEADER, 2'b00};
    localparam logic [2:0] ADDR_TARGET    = {REG_TARGET_PROTOCOL, 2'b00};

    localparam int         STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        item_valid   = 1'b0;
    wire         item_ready;
    logic [7:0]  data_byte    = '0;
    logic        first_byte   = 1'b0;
    logic        last_byte    = 1'b0;
    wire         result_valid;
    logic        result_ready = 1'b0;
    wire  [1:0]  status;
    wire  [7:0]  protocol;
    wire  [15:0] header_offset;
    wire  [15:0] fragment_offset;

    // from the checker
    int errors;
    int pending;
    int beats_in;
    int found_cnt;
    int missing_cnt;
    int bad_cnt;

    // stimulus state
    bit         calm       = 1'b0;   // no gaps on either side while set
    bit         cfg_last   = 1'b1;
    logic [7:0] cfg_proto  = TARGET_PROTOCOL_RST;
    bit         need_first = 1'b0;   // previous packet was cut off without a last beat
    logic [7:0] pkt[$];
    int         pkt_len;
    int         settings_run = 0;
    int         idle_cycles  = 0;

    ipv6_extension_header_walker_core dut (.*);

    ipv6ehw_walk_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(0, 4))
            0:       return PROTO_HOP_BY_HOP;
            1:       return PROTO_ROUTING;
            2:       return PROTO_FRAGMENT;
            3:       return PROTO_AUTH;
            default: return PROTO_DEST_OPTS;
        endcase
    endfunction

    // what the chain ends in; the sought protocol shows up now and then
    function automatic logic [7:0] pick_upper();
        case ($urandom_range(0, 9))
            0, 1, 2: return PROTO_TCP;
            3, 4:    return PROTO_UDP;
            5:       return PROTO_ICMP6;
            6:       return PROTO_NO_NEXT;
            7:       return cfg_proto;
            default: return rand_byte();
        endcase
    endfunction

    // result side back-pressure, one nonblocking write per edge
    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (calm)
                result_ready <= 1'b1;
            else if (hold > 0)
            begin
                hold--;
                result_ready <= 1'b0;
            end
            else
            begin
                hold = pick_gap();
                result_ready <= 1'b1;
            end
        end
    end

    // watchdog: any accepted beat or register write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((item_valid && item_ready) || (result_valid && result_ready) ||
                 (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ipv6_extension_header_walker_core_test: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one byte beat; valid stays up into the next beat unless a gap comes first
    task automatic send_beat(input logic [7:0] b, input logic f, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        data_byte  <= b;
        first_byte <= f;
        last_byte  <= l;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // two-phase apb write
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid, let every expected result come out, then a few spare cycles
    task automatic wait_for_quiet();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // builds one packet: short runt, random noise, or a well-formed chain with
    // random content that may end early
    task automatic build_packet();
        int         kind;
        int         n_ext;
        int         len;
        int         fill;
        logic [7:0] hops[$];
        logic [7:0] fo_hi;
        logic [7:0] fo_lo;
        logic [7:0] len_byte;
        pkt.delete();
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            fill = $urandom_range(1, 39);
            repeat (fill) pkt.push_back(rand_byte());
        end
        else if (kind < 12)
        begin
            fill = $urandom_range(40, 72);
            repeat (fill) pkt.push_back(rand_byte());
        end
        else
        begin
            n_ext = $urandom_range(0, 4);
            repeat (n_ext) hops.push_back(pick_ext());
            hops.push_back(pick_upper());
            // fixed header, next header field at byte 6
            repeat (40) pkt.push_back(rand_byte());
            pkt[6] = hops[0];
            for (int i = 0; i < n_ext; i++)
            begin
                pkt.push_back(hops[i + 1]);
                if (hops[i] == PROTO_FRAGMENT)
                begin
                    // a third of the fragments are non-first ones
                    if ($urandom_range(0, 2) == 0)
                    begin
                        fo_hi = rand_byte();
                        fo_lo = rand_byte();
                        if ({fo_hi, fo_lo[7:3]} == '0)
                            fo_hi = 8'h01;
                    end
                    else
                    begin
                        fo_hi = 8'h00;
                        fo_lo = rand_byte() & 8'h07;
                    end
                    pkt.push_back(rand_byte());
                    pkt.push_back(fo_hi);
                    pkt.push_back(fo_lo);
                    repeat (4) pkt.push_back(rand_byte());
                end
                else
                begin
                    len      = (hops[i] == PROTO_AUTH) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 2);
                    len_byte = 8'(len);
                    pkt.push_back(len_byte);
                    fill = (hops[i] == PROTO_AUTH) ? (len + 2) * 4 - 2 : (len + 1) * 8 - 2;
                    repeat (fill) pkt.push_back(rand_byte());
                end
            end
            fill = $urandom_range(0, 6);
            repeat (fill) pkt.push_back(rand_byte());
        end
        pkt_len = pkt.size();
        // truncated well-formed chains
        if (kind >= 12 && $urandom_range(0, 6) == 0)
            pkt_len = $urandom_range(38, pkt.size() - 1);
    endtask

    // sends pkt; mostly flagged with first_byte, sometimes not, and now and then
    // cut off without a last beat so the next packet restarts it
    task automatic send_packet(output int sent);
        bit use_first;
        bit cut_short;
        use_first = need_first || ($urandom_range(0, 9) != 0);
        cut_short = (pkt_len > 2) && ($urandom_range(0, 19) == 0);
        sent      = cut_short ? $urandom_range(1, pkt_len - 1) : pkt_len;
        for (int i = 0; i < sent; i++)
            send_beat(pkt[i], (i == 0) && use_first, (i == sent - 1) && !cut_short);
        need_first = cut_short;
    endtask

    task automatic run_setting(input bit last_mode, input logic [7:0] proto,
                               input bit write_regs);
        int phase_bytes;
        int phase_pkts;
        int sent;
        if (write_regs)
        begin
            wait_for_quiet();
            apb_write(ADDR_FIND_LAST, {31'b0, last_mode});
            apb_write(ADDR_TARGET, {24'b0, proto});
            cfg_last  = last_mode;
            cfg_proto = proto;
        end
        settings_run++;
        phase_bytes = 0;
        phase_pkts  = 0;
        while (phase_bytes < 170 || phase_pkts < 3)
        begin
            build_packet();
            send_packet(sent);
            phase_bytes += sent;
            phase_pkts++;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: packet right after reset with no first_byte
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        // one-beat packet, first and last together
        send_beat(8'hA5, 1'b1, 1'b1);
        // first_byte in mid-packet drops the old one silently
        send_beat(8'h3C, 1'b1, 1'b0);
        send_beat(8'h81, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h7E, 1'b0, 1'b0);
        send_beat(8'h01, 1'b0, 1'b1);
        // bytes after a last beat start a packet on their own
        send_beat(8'h5A, 1'b0, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);

        // random phases, reset settings first, then both extremes of each register
        run_setting(1'b1, TARGET_PROTOCOL_RST, 1'b0);
        run_setting(1'b0, PROTO_TCP, 1'b1);
        run_setting(1'b0, 8'h00, 1'b1);
        calm = 1'b1;
        run_setting(1'b0, 8'hFF, 1'b1);
        calm = 1'b0;
        run_setting(1'b1, 8'hFF, 1'b1);
        run_setting(1'b0, rand_byte(), 1'b1);
        run_setting(1'b1, 8'h00, 1'b1);

        // drain and give the core its latency before the verdict
        wait_for_quiet();
        repeat (4) @(posedge clk);
        $display("covered %0d byte beats over %0d register settings",
                 beats_in, settings_run);
        $display("results checked: %0d found, %0d not found, %0d bad message",
                 found_cnt, missing_cnt, bad_cnt);
        if (errors == 0 && pending == 0)
            $display("ipv6_extension_header_walker_core_test: done, clean");
        else
            $display("ipv6_extension_header_walker_core_test: done, errors");
        $finish;
    end

endmodule
